FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the sorted list engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SLE_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SLE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sle_pkg.sv
// ---------------------------------------------------------------------------
// sle_pkg
// Constants, codes and controller/datapath interface types of the engine.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY       = 16;
    localparam int IDX_W          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W          = $clog2(CAPACITY + 1);
    localparam int VALUE_W        = 32;
    localparam int POSITION_W     = 4;
    localparam int ENTRY_COUNT_W  = 5;
    localparam int CMP_W          = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_FETCH,
        S_INS_EVAL,
        S_INS_WRITE,
        S_SCAN_FETCH,
        S_SCAN_EVAL,
        S_DEL_FETCH,
        S_DEL_EVAL,
        S_READ_EVAL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADDR_PTR,
        ADDR_PTR_M1,
        ADDR_PTR_P1,
        ADDR_POS
    } addr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      rd_en;
        addr_sel_t addr_sel;
        logic      wr_en;
        logic      wr_value;
        logic      ptr_inc;
        logic      ptr_dec;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      res_en;
        status_t   res_status;
        logic      res_found;
        logic      res_read;
    } sle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_t req;
        logic full;
        logic at_zero;
        logic at_end;
        logic last;
        logic rd_lt;
        logic rd_eq;
        logic pos_ok;
    } sle_stat_t;

endpackage

FILE: hw/rtl/sle_ctrl.sv
// ---------------------------------------------------------------------------
// sle_ctrl
// Controller state machine that sequences the walk over the stored entries.
// ---------------------------------------------------------------------------
module sle_ctrl
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  sle_stat_t stat,
    output sle_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req)
                    REQ_INSERT: state_next = stat.full ? S_DONE : S_INS_FETCH;
                    REQ_READ:   state_next = stat.pos_ok ? S_READ_EVAL : S_DONE;
                    default:    state_next = S_SCAN_FETCH;
                endcase
            end
            S_INS_FETCH:  state_next = stat.at_zero ? S_INS_WRITE : S_INS_EVAL;
            S_INS_EVAL:   state_next = stat.rd_lt ? S_INS_WRITE : S_INS_FETCH;
            S_INS_WRITE:  state_next = S_DONE;
            S_SCAN_FETCH: state_next = stat.at_end ? S_DONE : S_SCAN_EVAL;
            S_SCAN_EVAL:
            begin
                if (stat.rd_eq)
                begin
                    state_next = (stat.req == REQ_SEARCH) ? S_DONE : S_DEL_FETCH;
                end
                else
                begin
                    state_next = S_SCAN_FETCH;
                end
            end
            S_DEL_FETCH:  state_next = stat.last ? S_DONE : S_DEL_EVAL;
            S_DEL_EVAL:   state_next = S_DEL_FETCH;
            S_READ_EVAL:  state_next = S_DONE;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.addr_sel   = ADDR_PTR;
        cmd.res_status = ST_OK;
        busy           = (state_reg != S_IDLE);
        done           = (state_reg == S_DONE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DISPATCH:
            begin
                case (stat.req)
                    REQ_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_FULL;
                        end
                    end
                    REQ_READ:
                    begin
                        if (stat.pos_ok)
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.addr_sel = ADDR_POS;
                        end
                        else
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_BAD_POS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_INS_FETCH:
            begin
                if (!stat.at_zero)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_PTR_M1;
                end
            end
            S_INS_EVAL:
            begin
                if (!stat.rd_lt)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.ptr_dec = 1'b1;
                end
            end
            S_INS_WRITE:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_value = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.res_en   = 1'b1;
            end
            S_SCAN_FETCH:
            begin
                if (stat.at_end)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_SCAN_EVAL:
            begin
                if (stat.rd_eq)
                begin
                    if (stat.req == REQ_SEARCH)
                    begin
                        cmd.res_en    = 1'b1;
                        cmd.res_found = 1'b1;
                    end
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_DEL_FETCH:
            begin
                if (stat.last)
                begin
                    cmd.cnt_dec   = 1'b1;
                    cmd.res_en    = 1'b1;
                    cmd.res_found = 1'b1;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_PTR_P1;
                end
            end
            S_DEL_EVAL:
            begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            S_READ_EVAL:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_read = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/sle_datapath.sv
// ---------------------------------------------------------------------------
// sle_datapath
// Entry memory, walk pointer, count and result registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_datapath
    import sle_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sle_cmd_t                     cmd,
    input  logic [1:0]                   req_type,
    input  logic signed [VALUE_W-1:0]    value,
    input  logic [POSITION_W-1:0]        position,
    output sle_stat_t                    stat,
    output logic [1:0]                   status,
    output logic                         found,
    output logic signed [VALUE_W-1:0]    read_value,
    output logic [ENTRY_COUNT_W-1:0]     entry_count
);

    logic [VALUE_W-1:0]        mem_array [CAPACITY];

    req_t                      req_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [POSITION_W-1:0]     position_reg;
    logic [CNT_W-1:0]          ptr_reg;
    logic [CNT_W-1:0]          ptr_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [VALUE_W-1:0] rd_data_reg;
    status_t                   status_reg;
    logic                      found_reg;
    logic signed [VALUE_W-1:0] read_value_reg;

    logic [CNT_W-1:0]          ptr_m1;
    logic [CNT_W:0]            ptr_p1;
    logic [IDX_W-1:0]          rd_addr;
    logic [VALUE_W-1:0]        wr_data;

    assign ptr_m1  = ptr_reg - CNT_W'(1);
    assign ptr_p1  = {1'b0, ptr_reg} + (CNT_W + 1)'(1);
    assign wr_data = cmd.wr_value ? value_reg : rd_data_reg;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_PTR:    rd_addr = ptr_reg[IDX_W-1:0];
            ADDR_PTR_M1: rd_addr = ptr_m1[IDX_W-1:0];
            ADDR_PTR_P1: rd_addr = ptr_p1[IDX_W-1:0];
            ADDR_POS:    rd_addr = IDX_W'(position_reg);
            default:     rd_addr = ptr_reg[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = (req_t'(req_type) == REQ_INSERT) ? count_reg : '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_p1[CNT_W-1:0];
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_array[ptr_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req_t'(req_type);
            value_reg    <= value;
            position_reg <= position;
        end
        if (cmd.res_en)
        begin
            status_reg     <= cmd.res_status;
            found_reg      <= cmd.res_found;
            read_value_reg <= cmd.res_read ? rd_data_reg : '0;
        end
    end

    assign stat.req     = req_reg;
    assign stat.full    = (count_reg >= CNT_W'(CAPACITY));
    assign stat.at_zero = (ptr_reg == '0);
    assign stat.at_end  = (ptr_reg == count_reg);
    assign stat.last    = (ptr_p1 == {1'b0, count_reg});
    assign stat.rd_lt   = (rd_data_reg < value_reg);
    assign stat.rd_eq   = (rd_data_reg == value_reg);
    assign stat.pos_ok  = (CMP_W'(position_reg) < CMP_W'(count_reg));

    assign status      = status_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign entry_count = ENTRY_COUNT_W'(count_reg);

    `SLE_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SLE_ASSERT(a_ptr_bound, clk, rst_n, ptr_reg <= count_reg, "walk pointer beyond count")
    `SLE_ASSERT_NEXT(a_count_step, clk, rst_n, cmd.cnt_inc, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count by one")

endmodule

FILE: hw/rtl/sorted_list_engine.sv
// ---------------------------------------------------------------------------
// sorted_list_engine
// Sorted list of signed 32-bit values with insert, search, delete and read.
// ---------------------------------------------------------------------------
// One transaction is handled at a time: start is seen only in idle, so a new
// request waits until the engine is back in idle. The receiver cannot stall;
// rst_n low empties the list.
module sorted_list_engine
    import sle_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic signed [VALUE_W-1:0]    value,
    input  logic [POSITION_W-1:0]        position,
    output logic                         done,
    output logic [1:0]                   status,
    output logic                         found,
    output logic signed [VALUE_W-1:0]    read_value,
    output logic [ENTRY_COUNT_W-1:0]     entry_count
);

    // The controller steers every memory access and pointer move; the
    // datapath reports comparisons and bounds back as a status bundle.
    sle_cmd_t  cmd;
    sle_stat_t stat;

    // Sequencer. A transaction is captured when start is seen in idle,
    // dispatched on its request code, walked over the entries when the request
    // needs it and then presented for one cycle with done high.
    sle_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Storage and arithmetic. Inserts shift entries that are not smaller than
    // the new value up one slot while walking down from the count; deletes find
    // the first equal entry and then pull the later entries down one slot.
    sle_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .value       (value),
        .position    (position),
        .stat        (stat),
        .status      (status),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

endmodule
